// ----- rtl/cpct_pkg.sv -----
// shared types and constants of the cartridge port command transfer block
`default_nettype none
package cpct_pkg;

  // fixed geometry of the transfer
  localparam int unsigned SECTOR_SHIFT   = 9;
  localparam int unsigned SECTOR_W       = 16;
  localparam int unsigned BYTES_W        = SECTOR_W + SECTOR_SHIFT;
  localparam int unsigned CMD_W          = 5;
  localparam logic [CMD_W-1:0] MAX_CMD_BYTES = CMD_W'(16);
  localparam logic [CMD_W-1:0] MIN_CMD_BYTES = CMD_W'(1);

  // configuration port geometry
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // reset values of the registers
  localparam logic [15:0] TIMEOUT_RESET = 16'd400;
  localparam logic        FORCE_RESET   = 1'b0;
  localparam logic [7:0]  ERROR_RESET   = 8'hFF;

  // input item opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_FORCE   = 2'd1,
    REG_ERROR   = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LOCK   = 3'd1,
    PH_CMD    = 3'd2,
    PH_DATA   = 3'd3,
    PH_STATUS = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ACT_WAIT   = 3'd0,
    ACT_LOCK   = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_READ   = 3'd3,
    ACT_FINISH = 3'd4
  } action_e;

  typedef struct packed {
    logic                op;
    logic                read_not_write;
    logic [CMD_W-1:0]    cmd_length;
    logic [SECTOR_W-1:0] sector_count;
    logic                wants_more;
    logic                device_idle;
    logic                lock_busy;
    logic                tick;
    logic [7:0]          out_byte;
    logic [7:0]          in_byte;
  } in_item_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] byte_value;
    logic       is_command;
    logic       success;
    logic [7:0] status_byte;
    logic       lock_held;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/cpct_if.sv -----
// valid/ready channel interfaces for input and result transactions
`default_nettype none
interface cpct_in_if;
  logic               valid;
  logic               ready;
  cpct_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cpct_out_if;
  logic                valid;
  logic                ready;
  cpct_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/cartridge_port_command_transfer.sv -----
// host-side command transfer sequencer over the cartridge port byte link
//
//   channel   direction  handshake        contents
//   in_i      sink       valid/ready      start or poll transaction
//   out_o     source     valid/ready      one result transaction per input
//   apb       slave      psel/penable     timeout, force lock, error status
//
// one transaction per cycle while no result waits on a stalled output:
// the sequencer step is computed straight from the accepted input and the
// state registers into the result register, valid in the next cycle.
// in_i.ready is high whenever the result register is empty or being taken,
// so a stalled output only holds off the input while a result waits.
// rst_ni clears the phase, counters and registers to their reset values.
`default_nettype none
module cartridge_port_command_transfer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  cpct_in_if.sink                            in_i,
  cpct_out_if.source                         out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cpct_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [cpct_pkg::DATA_W-1:0]   pwdata,
  output logic      [cpct_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  // configuration registers
  logic [15:0] timeout_q;
  logic        force_q;
  logic [7:0]  error_q;

  // sequencer state
  cpct_pkg::phase_e                      phase_q, phase_d;
  logic [15:0]                           elapsed_q, elapsed_d;
  logic [cpct_pkg::CMD_W-1:0]            cmd_index_q, cmd_index_d;
  logic [cpct_pkg::BYTES_W-1:0]          bytes_left_q, bytes_left_d;
  logic [7:0]                            last_data_q, last_data_d;
  logic                                  dir_read_q, dir_read_d;
  logic [cpct_pkg::CMD_W-1:0]            cmds_total_q, cmds_total_d;
  logic                                  holding_q, holding_d;

  // result register
  logic                  out_valid_q;
  cpct_pkg::out_item_t   out_data_q;
  cpct_pkg::out_item_t   res;

  logic                  in_acc;
  logic                  cfg_wr;
  cpct_pkg::reg_idx_e    reg_idx;

  logic [15:0]                elapsed_inc;
  logic                       timed_out;
  logic                       finish_now;
  logic                       fin_ok;
  logic [7:0]                 fin_status;
  logic [cpct_pkg::CMD_W-1:0] len;
  logic [cpct_pkg::CMD_W-1:0] idx_inc;

  // handshakes
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // configuration port decode
  assign pready  = 1'b1;
  assign reg_idx = cpct_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      cpct_pkg::REG_TIMEOUT: prdata = cpct_pkg::DATA_W'(timeout_q);
      cpct_pkg::REG_FORCE:   prdata = cpct_pkg::DATA_W'(force_q);
      cpct_pkg::REG_ERROR:   prdata = cpct_pkg::DATA_W'(error_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= cpct_pkg::TIMEOUT_RESET;
      force_q   <= cpct_pkg::FORCE_RESET;
      error_q   <= cpct_pkg::ERROR_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        cpct_pkg::REG_TIMEOUT: timeout_q <= pwdata[15:0];
        cpct_pkg::REG_FORCE:   force_q   <= pwdata[0];
        cpct_pkg::REG_ERROR:   error_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // saturating tick count and timeout compare
  assign elapsed_inc = (in_i.data.tick && (elapsed_q != 16'hFFFF)) ? elapsed_q + 16'd1
                                                                   : elapsed_q;
  assign timed_out   = elapsed_inc >= timeout_q;
  assign idx_inc     = cmd_index_q + cpct_pkg::CMD_W'(1);

  // command length clamp
  always_comb begin
    len = in_i.data.cmd_length;
    if (len == '0) len = cpct_pkg::MIN_CMD_BYTES;
    if (len > cpct_pkg::MAX_CMD_BYTES) len = cpct_pkg::MAX_CMD_BYTES;
  end

  // sequencer step for one transaction
  always_comb begin
    phase_d      = phase_q;
    elapsed_d    = elapsed_q;
    cmd_index_d  = cmd_index_q;
    bytes_left_d = bytes_left_q;
    last_data_d  = last_data_q;
    dir_read_d   = dir_read_q;
    cmds_total_d = cmds_total_q;
    holding_d    = holding_q;
    finish_now   = 1'b0;
    fin_ok       = 1'b0;
    fin_status   = '0;
    res          = '0;
    res.action   = cpct_pkg::ACT_WAIT;

    if (in_acc) begin
      if (in_i.data.op == cpct_pkg::OP_START) begin
        // new command drops any running one
        dir_read_d   = in_i.data.read_not_write;
        cmds_total_d = len;
        bytes_left_d = cpct_pkg::BYTES_W'(in_i.data.sector_count) << cpct_pkg::SECTOR_SHIFT;
        cmd_index_d  = '0;
        elapsed_d    = '0;
        holding_d    = 1'b0;
        phase_d      = cpct_pkg::PH_LOCK;
      end else if (phase_q == cpct_pkg::PH_IDLE) begin
        res.lock_held = holding_q;
      end else begin
        elapsed_d = elapsed_inc;
        if (phase_q == cpct_pkg::PH_LOCK) begin
          // lock acquisition
          if (force_q || !in_i.data.lock_busy) begin
            holding_d   = 1'b1;
            elapsed_d   = '0;
            cmd_index_d = '0;
            phase_d     = cpct_pkg::PH_CMD;
            res.action  = cpct_pkg::ACT_LOCK;
          end else if (timed_out) begin
            finish_now = 1'b1;
            fin_status = error_q;
          end
        end else if (phase_q == cpct_pkg::PH_CMD && cmd_index_q == '0) begin
          // first command byte goes out without a handshake
          res.action     = cpct_pkg::ACT_WRITE;
          res.byte_value = in_i.data.out_byte;
          res.is_command = 1'b1;
          cmd_index_d    = cpct_pkg::CMD_W'(1);
          if (cpct_pkg::CMD_W'(1) >= cmds_total_q) begin
            last_data_d = '0;
            phase_d     = (bytes_left_q == '0) ? cpct_pkg::PH_STATUS : cpct_pkg::PH_DATA;
          end
        end else if (!in_i.data.wants_more) begin
          // peer not asking: idle ends the transfer, else check timeout
          if (in_i.data.device_idle) begin
            finish_now = 1'b1;
            fin_ok     = (phase_q != cpct_pkg::PH_CMD);
            fin_status = last_data_q;
          end else if (timed_out) begin
            finish_now = 1'b1;
            fin_status = error_q;
          end
        end else begin
          case (phase_q)
            cpct_pkg::PH_CMD: begin
              res.action     = cpct_pkg::ACT_WRITE;
              res.byte_value = in_i.data.out_byte;
              res.is_command = 1'b1;
              cmd_index_d    = idx_inc;
              if (idx_inc >= cmds_total_q) begin
                last_data_d = '0;
                phase_d     = (bytes_left_q == '0) ? cpct_pkg::PH_STATUS
                                                   : cpct_pkg::PH_DATA;
              end
            end
            cpct_pkg::PH_DATA: begin
              if (dir_read_q) begin
                res.action     = cpct_pkg::ACT_READ;
                res.byte_value = in_i.data.in_byte;
              end else begin
                res.action     = cpct_pkg::ACT_WRITE;
                res.byte_value = in_i.data.out_byte;
              end
              last_data_d = in_i.data.in_byte;
              if (bytes_left_q != '0) begin
                bytes_left_d = bytes_left_q - cpct_pkg::BYTES_W'(1);
              end
              if (bytes_left_q <= cpct_pkg::BYTES_W'(1)) begin
                phase_d = cpct_pkg::PH_STATUS;
              end
            end
            default: begin
              // status byte
              finish_now = 1'b1;
              fin_ok     = 1'b1;
              fin_status = in_i.data.in_byte;
            end
          endcase
        end

        if (finish_now) begin
          phase_d         = cpct_pkg::PH_IDLE;
          holding_d       = 1'b0;
          res.action      = cpct_pkg::ACT_FINISH;
          res.success     = fin_ok;
          res.status_byte = fin_status;
        end
        res.lock_held = holding_d;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= cpct_pkg::PH_IDLE;
      elapsed_q    <= '0;
      cmd_index_q  <= '0;
      bytes_left_q <= '0;
      last_data_q  <= '0;
      dir_read_q   <= 1'b0;
      cmds_total_q <= '0;
      holding_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      elapsed_q    <= elapsed_d;
      cmd_index_q  <= cmd_index_d;
      bytes_left_q <= bytes_left_d;
      last_data_q  <= last_data_d;
      dir_read_q   <= dir_read_d;
      cmds_total_q <= cmds_total_d;
      holding_q    <= holding_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= res;
    end
  end

  // a finish result never reports the lock as held
  a_finish_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.action == cpct_pkg::ACT_FINISH) |-> !out_data_q.lock_held)
    else $error("finish result reports lock held");

  // the lock is only held in the command, data or status phase
  a_lock_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    holding_q |-> (phase_q == cpct_pkg::PH_CMD || phase_q == cpct_pkg::PH_DATA ||
                   phase_q == cpct_pkg::PH_STATUS))
    else $error("lock held outside transfer phases");

  // a start always lands in the lock phase with the lock released
  a_start_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.data.op == cpct_pkg::OP_START) |=>
      (phase_q == cpct_pkg::PH_LOCK) && !holding_q && (elapsed_q == '0))
    else $error("start did not enter lock phase");

  // data phase always has bytes left to move
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == cpct_pkg::PH_DATA) |-> (bytes_left_q != '0))
    else $error("data phase with no bytes left");

  // an empty result register never holds off the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

endmodule
`default_nettype wire
